### hw/rtl/imconv_pkg.sv
// imconv_pkg: shared types and constants of the streaming 2d convolution
// used by the front end, the command queue, the back end and the top level
package imconv_pkg;

    localparam int MAX_TAPS   = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int NLB      = MAX_TAPS - 1;
    localparam int PIX_W    = 8;
    localparam int COEF_W   = 12;
    localparam int ROWCFG_W = 60;
    localparam int WREG_W   = 11;
    localparam int HREG_W   = 13;
    localparam int KREG_W   = 3;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int LIN_W    = $clog2(2 * MAX_WIDTH + 3);
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int RSUM_W   = PROD_W + 3;
    localparam int SUM_W    = 25;
    localparam int CFG_W    = 60;
    localparam int QDEPTH   = 4;

    typedef enum logic [2:0] {
        IDX_WIDTH,
        IDX_HEIGHT,
        IDX_KSIZE,
        IDX_COEF_A,
        IDX_COEF_B,
        IDX_COEF_C,
        IDX_COEF_D,
        IDX_COEF_E
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             emit;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [WID_W-1:0]                       width;
        logic [HGT_W-1:0]                       height;
        logic [1:0]                             radius;
        logic [MAX_TAPS-1:0][ROWCFG_W-1:0]      coef;
    } cfg_t;

endpackage

### hw/rtl/imconv_fifo.sv
// imconv_fifo: short command queue between front end and back end
// depends on imconv_pkg for the command type
module imconv_fifo
    import imconv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = $clog2(QDEPTH);

    cmd_t               q_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;

    assign full  = count_reg == (PTR_W+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/imconv_front.sv
// imconv_front: configuration registers, raster counters and item classification
// depends on imconv_pkg; feeds commands to the queue
module imconv_front
    import imconv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIX_W-1:0]  in_pixel,
    input  logic              in_drain,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_data,
    output cfg_t              cfg
);

    logic [WREG_W-1:0]                  width_reg;
    logic [HREG_W-1:0]                  height_reg;
    logic [KREG_W-1:0]                  ksize_reg;
    logic [MAX_TAPS-1:0][ROWCFG_W-1:0]  coef_reg;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [HGT_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [LIN_W-1:0] lin_reg, lin_next;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [KREG_W-1:0] k_eff;
    logic [1:0]       r_eff;
    logic [LIN_W-1:0] delay;
    logic             done, accept, emit, geom_wr, fill;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (width_reg > WREG_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HGT_W'(1);
        end else if (height_reg > HREG_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(height_reg);
        end
        if (ksize_reg == '0) begin
            k_eff = KREG_W'(1);
        end else if (ksize_reg > KREG_W'(5)) begin
            k_eff = KREG_W'(5);
        end else begin
            k_eff = ksize_reg[0] ? ksize_reg : ksize_reg - 1'b1;
        end
        r_eff = k_eff[2:1];
        unique case (r_eff)
            2'd1:    delay = LIN_W'(w_eff) + LIN_W'(1);
            2'd2:    delay = LIN_W'({w_eff, 1'b0}) + LIN_W'(2);
            default: delay = '0;
        endcase
    end

    assign cfg.width  = w_eff;
    assign cfg.height = h_eff;
    assign cfg.radius = r_eff;
    assign cfg.coef   = coef_reg;

    // short frame: pad the stream with empty slots until the window lines up
    assign fill     = done && (lin_reg < delay);
    assign in_ready = !q_full && !fill;
    assign accept   = in_valid && !q_full && !fill;
    assign done     = in_row_reg == h_eff;
    assign geom_wr  = cfg_wr_en && (cfg_index == IDX_WIDTH || cfg_index == IDX_HEIGHT
                                    || cfg_index == IDX_KSIZE);

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lin_next     = lin_reg;
        q_push       = 1'b0;
        emit         = 1'b0;
        if ((accept && (done || !in_drain)) || (fill && !q_full)) begin
            q_push = 1'b1;
            if (done && !fill) begin
                emit = 1'b1;
            end else begin
                emit = lin_reg >= delay;
                if (lin_reg < delay) begin
                    lin_next = lin_reg + 1'b1;
                end
            end
            if (WID_W'(in_col_reg) + WID_W'(1) >= w_eff) begin
                in_col_next = '0;
                if (!done) begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (emit) begin
                if (WID_W'(out_col_reg) + WID_W'(1) >= w_eff) begin
                    out_col_next = '0;
                    if (HGT_W'(out_row_reg) + HGT_W'(1) >= h_eff) begin
                        out_row_next = '0;
                        in_col_next  = '0;
                        in_row_next  = '0;
                        lin_next     = '0;
                    end else begin
                        out_row_next = out_row_reg + 1'b1;
                    end
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
        if (geom_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lin_next     = '0;
        end
    end

    always_comb begin
        q_data.pix  = in_pixel;
        q_data.col  = in_col_reg;
        q_data.emit = emit;
        q_data.orow = out_row_reg;
        q_data.ocol = out_col_reg;
        q_data.last = (HGT_W'(out_row_reg) + HGT_W'(1) == h_eff)
                      && (WID_W'(out_col_reg) + WID_W'(1) == w_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WREG_W'(1024);
            height_reg  <= HREG_W'(1024);
            ksize_reg   <= KREG_W'(3);
            coef_reg    <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lin_reg     <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lin_reg     <= lin_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    IDX_WIDTH:  width_reg   <= cfg_wdata[WREG_W-1:0];
                    IDX_HEIGHT: height_reg  <= cfg_wdata[HREG_W-1:0];
                    IDX_KSIZE:  ksize_reg   <= cfg_wdata[KREG_W-1:0];
                    IDX_COEF_A: coef_reg[0] <= cfg_wdata[ROWCFG_W-1:0];
                    IDX_COEF_B: coef_reg[1] <= cfg_wdata[ROWCFG_W-1:0];
                    IDX_COEF_C: coef_reg[2] <= cfg_wdata[ROWCFG_W-1:0];
                    IDX_COEF_D: coef_reg[3] <= cfg_wdata[ROWCFG_W-1:0];
                    IDX_COEF_E: coef_reg[4] <= cfg_wdata[ROWCFG_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

endmodule

### hw/rtl/imconv_back.sv
// imconv_back: line memories, tap window, multiply and adder pipeline, output register
// depends on imconv_pkg; pulls commands from the queue
module imconv_back
    import imconv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    q_empty,
    input  cmd_t                    q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] out_sum,
    output logic                    out_last
);

    logic adv;

    logic [PIX_W-1:0] lb_mem [NLB][MAX_WIDTH];
    logic [NLB-1:0][PIX_W-1:0] rd_reg, fwd_reg, rd_eff;
    logic fwd_hit_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    cmd_t c1_reg;
    logic             emit2_reg;
    logic [ROW_W-1:0] row2_reg;
    logic [COL_W-1:0] col2_reg;
    logic             last2_reg, last3_reg, last4_reg;

    logic [MAX_TAPS-1:0][MAX_TAPS-1:0][PIX_W-1:0] win_reg;
    logic [MAX_TAPS-1:0][PIX_W-1:0] col_vec;

    logic signed [PROD_W-1:0] prod_reg  [MAX_TAPS][MAX_TAPS];
    logic signed [PROD_W-1:0] prod_next [MAX_TAPS][MAX_TAPS];
    logic signed [RSUM_W-1:0] rsum_reg  [MAX_TAPS];
    logic signed [RSUM_W-1:0] rsum_next [MAX_TAPS];
    logic signed [SUM_W-1:0]  sum_next;

    logic [MAX_TAPS-1:0] row_ok, col_ok;
    logic [HGT_W:0]      ry;
    logic [WID_W:0]      cx;
    logic [2:0]          diam, jr, jc;
    logic [PIX_W-1:0]    tap;

    assign adv   = !out_valid || out_ready;
    assign q_pop = adv && !q_empty;

    always_comb begin
        for (int k = 0; k < NLB; k++) begin
            rd_eff[k] = fwd_hit_reg ? fwd_reg[k] : rd_reg[k];
        end
        col_vec[0] = c1_reg.pix;
        for (int k = 1; k < MAX_TAPS; k++) begin
            col_vec[k] = rd_eff[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int k = 0; k < NLB; k++) begin
                rd_reg[k]  <= lb_mem[k][q_head.col];
                fwd_reg[k] <= col_vec[k];
            end
        end
        if (adv && v1_reg) begin
            for (int k = 0; k < NLB; k++) begin
                lb_mem[k][c1_reg.col] <= col_vec[k];
            end
        end
    end

    always_comb begin
        diam = {cfg.radius, 1'b0};
        for (int f = 0; f < MAX_TAPS; f++) begin
            ry = (HGT_W+1)'(row2_reg) + (HGT_W+1)'(f);
            row_ok[f] = (3'(f) <= diam) && (ry >= (HGT_W+1)'(cfg.radius))
                        && (ry < (HGT_W+1)'(cfg.height) + (HGT_W+1)'(cfg.radius));
            cx = (WID_W+1)'(col2_reg) + (WID_W+1)'(f);
            col_ok[f] = (3'(f) <= diam) && (cx >= (WID_W+1)'(cfg.radius))
                        && (cx < (WID_W+1)'(cfg.width) + (WID_W+1)'(cfg.radius));
        end
        for (int fy = 0; fy < MAX_TAPS; fy++) begin
            for (int fx = 0; fx < MAX_TAPS; fx++) begin
                jr = diam - 3'(fy);
                jc = diam - 3'(fx);
                tap = (row_ok[fy] && col_ok[fx]) ? win_reg[jc][jr] : '0;
                prod_next[fy][fx] = $signed({1'b0, tap})
                                    * $signed(cfg.coef[fy][COEF_W*fx +: COEF_W]);
            end
        end
        for (int fy = 0; fy < MAX_TAPS; fy++) begin
            rsum_next[fy] = '0;
            for (int fx = 0; fx < MAX_TAPS; fx++) begin
                rsum_next[fy] = rsum_next[fy] + RSUM_W'(prod_reg[fy][fx]);
            end
        end
        sum_next = '0;
        for (int fy = 0; fy < MAX_TAPS; fy++) begin
            sum_next = sum_next + SUM_W'(rsum_reg[fy]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            out_valid   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= !q_empty;
            fwd_hit_reg <= !q_empty && v1_reg && (q_head.col == c1_reg.col);
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg && emit2_reg;
            v4_reg      <= v3_reg;
            out_valid   <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg    <= q_head;
            emit2_reg <= c1_reg.emit;
            row2_reg  <= c1_reg.orow;
            col2_reg  <= c1_reg.ocol;
            last2_reg <= c1_reg.last;
            if (v1_reg) begin
                for (int j = MAX_TAPS - 1; j > 0; j--) begin
                    win_reg[j] <= win_reg[j-1];
                end
                win_reg[0] <= col_vec;
            end
            prod_reg  <= prod_next;
            last3_reg <= last2_reg;
            rsum_reg  <= rsum_next;
            last4_reg <= last3_reg;
            out_sum   <= sum_next;
            out_last  <= last4_reg;
        end
    end

endmodule

### hw/rtl/image_conv2d_zero_pad.sv
// image_conv2d_zero_pad: streaming 2d correlation with zero padding, one pixel per clock while not stalled
// a result passes the command queue, then the c1, window, product, row sum and output registers
// throughput: one request per cycle while m_tready keeps up, set by the line memories and the tap
// pipeline; a frame of fewer than r*W+r pixels holds s_tready low for the shortfall after its end
// reset: synchronous active-low aresetn clears counters, queue and pipeline; line memories
// are not cleared, rows outside the current frame are masked to zero
module image_conv2d_zero_pad
    import imconv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // pixel
    input  logic              s_tuser,   // drain
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // conv_sum
    output logic              m_tlast
);

    cfg_t cfg;
    cmd_t q_in, q_head;
    logic q_push, q_pop, q_full, q_empty;
    logic signed [SUM_W-1:0] sum;

    imconv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata),
        .in_drain  (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .cfg       (cfg)
    );

    imconv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    imconv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (sum),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(32-SUM_W){1'b0}}, sum};

endmodule

### sim/imconv_checker.sv
// imconv_checker: watches the register port and both streams of image_conv2d_zero_pad,
// predicts each convolution result and compares it; needs imconv_pkg
module imconv_checker
    import imconv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata,
    input  logic             m_tlast,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = (MAX_TAPS - 1) * MAX_WIDTH + MAX_TAPS;

    typedef struct {
        logic [24:0] conv_sum;
        logic        frame_last;
    } pix_result_t;

    pix_result_t expected_sums[$];
    logic [7:0]  ring_pix [RING];
    logic [10:0] reg_width;
    logic [12:0] reg_height;
    logic [2:0]  reg_ksize;
    logic [59:0] coef_row [5];
    int unsigned in_col, in_row, out_col, out_row;

    function automatic int unsigned cur_width();
        int unsigned w;
        w = reg_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned cur_height();
        int unsigned h;
        h = reg_height;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int unsigned cur_ksize();
        int unsigned k;
        k = reg_ksize;
        if (k == 0) k = 1;
        if (k % 2 == 0) k = k - 1;
        if (k > 5) k = 5;
        return k;
    endfunction

    task automatic restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_sum();
        int unsigned w, h, k;
        int          r, iy, ix;
        longint      acc;
        logic [11:0] c;
        logic [7:0]  p;
        pix_result_t res;
        w = cur_width();
        h = cur_height();
        k = cur_ksize();
        r = k / 2;
        acc = 0;
        for (int fy = 0; fy < k; fy++) begin
            for (int fx = 0; fx < k; fx++) begin
                iy = out_row + fy - r;
                ix = out_col + fx - r;
                p = 0;
                if (iy >= 0 && iy < h && ix >= 0 && ix < w)
                    p = ring_pix[(iy * w + ix) % RING];
                c = coef_row[fy][12*fx +: 12];
                acc += longint'(p) * longint'($signed(c));
            end
        end
        res.conv_sum = acc[24:0];
        res.frame_last = (out_row == h - 1) && (out_col == w - 1);
        expected_sums.push_back(res);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) restart_frame();
    endtask

    task automatic take_request(logic [7:0] pix, logic drain);
        int unsigned w, h, r, lin;
        w = cur_width();
        h = cur_height();
        r = cur_ksize() / 2;
        if (in_row < h) begin
            if (drain) return;
            lin = in_row * w + in_col;
            ring_pix[lin % RING] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (lin >= r * w + r) predict_sum();
        end else begin
            predict_sum();
        end
    endtask

    always @(posedge aclk) begin
        pix_result_t want;
        if (!aresetn) begin
            expected_sums.delete();
            reg_width = 1024;
            reg_height = 1024;
            reg_ksize = 3;
            foreach (coef_row[i]) coef_row[i] = '0;
            restart_frame();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    IDX_WIDTH: begin
                        reg_width = cfg_wdata[10:0];
                        restart_frame();
                    end
                    IDX_HEIGHT: begin
                        reg_height = cfg_wdata[12:0];
                        restart_frame();
                    end
                    IDX_KSIZE: begin
                        reg_ksize = cfg_wdata[2:0];
                        restart_frame();
                    end
                    IDX_COEF_A: coef_row[0] = cfg_wdata;
                    IDX_COEF_B: coef_row[1] = cfg_wdata;
                    IDX_COEF_C: coef_row[2] = cfg_wdata;
                    IDX_COEF_D: coef_row[3] = cfg_wdata;
                    IDX_COEF_E: coef_row[4] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: tdata=%h tlast=%b", m_tdata, m_tlast);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== {7'b0, want.conv_sum} || m_tlast !== want.frame_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                     {7'b0, want.conv_sum}, want.frame_last, m_tdata, m_tlast);
                    end
                end
            end
        end
        pending = expected_sums.size();
    end

endmodule

### sim/image_conv2d_zero_pad_test.sv
// image_conv2d_zero_pad_test: drives frames with directed and random geometry, kernels and
// pixels into image_conv2d_zero_pad; needs imconv_pkg, the rtl and imconv_checker
module image_conv2d_zero_pad_test;
    import imconv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             cfg_wr_en = 0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tuser = 0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [31:0]      m_tdata;
    logic             m_tlast;
    int               fail_count, pending;
    bit               calm = 0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               random_items = 0;

    always #4 aclk = ~aclk;

    image_conv2d_zero_pad dut (.*);
    imconv_checker chk (.*);

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_tready = 0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready = 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(logic [7:0] pix, logic drain);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = pix;
        s_tuser = drain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    function automatic logic [59:0] rand_row();
        return 60'({$urandom, $urandom});
    endfunction

    // pix_mode: 0 random, 1 all 255, 2 alternate 0/255
    task automatic run_frame(int w, int h, int k, logic [59:0] rows [5], int pix_mode,
                             bit pause_mid);
        int ew, eh, ek, r, total, flush;
        logic [7:0] p;
        wait_drained();
        write_reg(IDX_WIDTH, w);
        write_reg(IDX_HEIGHT, h);
        write_reg(IDX_KSIZE, k);
        write_reg(IDX_COEF_A, rows[0]);
        write_reg(IDX_COEF_B, rows[1]);
        write_reg(IDX_COEF_C, rows[2]);
        write_reg(IDX_COEF_D, rows[3]);
        write_reg(IDX_COEF_E, rows[4]);
        ew = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
        eh = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
        ek = (k == 0) ? 1 : k;
        if (ek % 2 == 0) ek--;
        if (ek > 5) ek = 5;
        r = ek / 2;
        total = ew * eh;
        flush = (r * ew + r < total) ? r * ew + r : total;
        for (int i = 0; i < total; i++) begin
            if (pause_mid && i == total / 2) begin
                s_tvalid = 0;
                while (pending != 0) @(negedge aclk);
            end
            // drain requests inside the frame are ignored
            if ($urandom_range(0, 15) == 0) send_request($urandom, 1);
            case (pix_mode)
                1: p = 8'hFF;
                2: p = i[0] ? 8'hFF : 8'h00;
                default: p = $urandom;
            endcase
            send_request(p, 0);
            random_items++;
        end
        // past the frame end a pixel acts as a drain
        for (int i = 0; i < flush; i++) begin
            send_request($urandom, $urandom_range(0, 3) != 0);
            random_items++;
        end
    endtask

    initial begin
        logic [59:0] rows [5];
        repeat (3) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        foreach (rows[i]) rows[i] = {5{12'h7FF}};
        run_frame(5, 5, 5, rows, 1, 1);
        foreach (rows[i]) rows[i] = {5{12'h800}};
        run_frame(5, 4, 3, rows, 2, 0);
        foreach (rows[i]) rows[i] = rand_row();
        run_frame(0, 0, 0, rows, 0, 0);
        run_frame(3, 3, 2, rows, 0, 0);
        run_frame(4, 3, 6, rows, 0, 0);
        run_frame(2047, 1, 1, rows, 0, 0);

        while (random_items < 1500) begin
            if (random_items > 1200) calm = 1;
            foreach (rows[i]) rows[i] = rand_row();
            run_frame($urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12),
                      $urandom_range(1, 10), $urandom_range(0, 7), rows,
                      $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0, 0);
        end

        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/imconv_pkg.sv
hw/rtl/imconv_fifo.sv
hw/rtl/imconv_front.sv
hw/rtl/imconv_back.sv
hw/rtl/image_conv2d_zero_pad.sv
sim/imconv_checker.sv
sim/image_conv2d_zero_pad_test.sv
